@@ src/oidd_pkg.sv @@
package oidd_pkg;

	// Byte position counter width and its saturation value
	localparam int unsigned POS_W = 11;
	localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

	// Header length in bytes: count, prefix, include, reserved
	localparam logic [POS_W-1:0] HDR_BYTES = 11'd4;

	// Status codes on the closing word of an identifier
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SHORT  = 2'd1;
	localparam logic [1:0] ST_LENGTH = 2'd2;

	// Index of the final word of the internet prefix burst
	localparam logic [2:0] BURST_LAST = 3'd4;

	// One queued record: a single result word, or a prefix burst of five
	typedef struct packed {
		logic        burst;
		logic [31:0] subid;
		logic        has_subid;
		logic        end_of_oid;
		logic [1:0]  status;
	} oidd_rec_t;

	// Words of the burst: 1.3.6.1 followed by the prefix byte
	function automatic logic [31:0] burst_word(input logic [2:0] idx, input logic [7:0] prefix);
		logic [31:0] w;
		unique case (idx)
			3'd0: w = 32'd1;
			3'd1: w = 32'd3;
			3'd2: w = 32'd6;
			3'd3: w = 32'd1;
			default: w = {24'd0, prefix};
		endcase
		return w;
	endfunction

endpackage

@@ src/oidd_byte_if.sv @@
interface oidd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ src/oidd_subid_if.sv @@
interface oidd_subid_if;
	logic        valid;
	logic        ready;
	logic [31:0] subid;
	logic        has_subid;
	logic        end_of_oid;
	logic [1:0]  status;

	modport source (output valid, output subid, output has_subid, output end_of_oid,
		output status, input ready);
	modport sink (input valid, input subid, input has_subid, input end_of_oid,
		input status, output ready);
endinterface

@@ src/oidd_decode.sv @@
module oidd_decode import oidd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  logic [7:0] data_byte,
	input  logic      last_byte,
	output logic      busy,
	output logic      push,
	output oidd_rec_t rec
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       count_q;
	logic [23:0]      partial_q;

	logic [POS_W-1:0] lim;
	logic [POS_W-1:0] total;
	logic             in_groups;
	logic             word_done;
	logic [31:0]      sub_word;
	logic [1:0]       st;

	// Input stage: register the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign busy = valid_s1;

	// Length bookkeeping and subidentifier assembly
	always_comb begin
		lim       = HDR_BYTES + {1'b0, count_q, 2'b00};
		in_groups = (pos_q >= HDR_BYTES) && (pos_q < lim);
		word_done = in_groups && (pos_q[1:0] == 2'd3);
		sub_word  = {partial_q, byte_s1};
		total     = (pos_q == POS_MAX) ? POS_MAX : pos_q + 11'd1;
		priority if (total < HDR_BYTES) st = ST_SHORT;
		else if (total != lim)         st = ST_LENGTH;
		else                           st = ST_OK;
	end

	// Build the record for this byte, if it yields one
	always_comb begin
		push = 1'b0;
		rec  = '{burst: 1'b0, subid: 32'd0, has_subid: 1'b0, end_of_oid: 1'b0,
			status: ST_OK};
		if (valid_s1) begin
			if (last_s1) begin
				push           = 1'b1;
				rec.end_of_oid = 1'b1;
				rec.status     = st;
				if (st == ST_OK && word_done) begin
					rec.subid     = sub_word;
					rec.has_subid = 1'b1;
				end
			end else if (pos_q == 11'd1 && byte_s1 != 8'd0) begin
				push          = 1'b1;
				rec.burst     = 1'b1;
				rec.subid     = {24'd0, byte_s1};
				rec.has_subid = 1'b1;
			end else if (word_done) begin
				push          = 1'b1;
				rec.subid     = sub_word;
				rec.has_subid = 1'b1;
			end
		end
	end

	// Advance the per-identifier state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			count_q   <= '0;
			partial_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				pos_q     <= '0;
				count_q   <= '0;
				partial_q <= '0;
			end else begin
				if (pos_q == '0) begin
					count_q <= byte_s1;
				end
				if (in_groups) begin
					partial_q <= word_done ? 24'd0 : {partial_q[15:0], byte_s1};
				end
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 11'd1;
				end
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> pos_q == '0 && partial_q == '0)
		else $error("state not cleared after final word");

	a_burst_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		push && rec.burst |-> !rec.end_of_oid && rec.status == ST_OK)
		else $error("prefix burst marked as closing word");

endmodule

@@ src/oidd_queue.sv @@
module oidd_queue import oidd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  oidd_rec_t                  rec,
	output logic [$clog2(DEPTH+1)-1:0] level,
	oidd_subid_if.source               subids
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] LVL_FULL = CW'(DEPTH);

	oidd_rec_t     mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] level_q;
	logic [2:0]    idx_q;
	oidd_rec_t     head;
	logic          fire;
	logic          pop;

	assign head  = mem_q[rd_q];
	assign level = level_q;
	assign fire  = subids.valid && subids.ready;
	assign pop   = fire && (!head.burst || idx_q == BURST_LAST);

	// Present the head record, expanding a burst one word at a time
	always_comb begin
		subids.valid = level_q != '0;
		if (head.burst) begin
			subids.subid      = burst_word(idx_q, head.subid[7:0]);
			subids.has_subid  = 1'b1;
			subids.end_of_oid = 1'b0;
			subids.status     = ST_OK;
		end else begin
			subids.subid      = head.subid;
			subids.has_subid  = head.has_subid;
			subids.end_of_oid = head.end_of_oid;
			subids.status     = head.status;
		end
	end

	// Store records
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= rec;
		end
	end

	// Advance pointers, fill level and burst index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
			idx_q   <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
			if (fire) begin
				idx_q <= pop ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> level_q < LVL_FULL || pop)
		else $error("record pushed into full queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_FULL)
		else $error("queue level out of range");

	a_idx_burst: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> level_q != '0 && head.burst)
		else $error("burst index set without a burst at the head");

endmodule

@@ src/oid_binary_decoder.sv @@
// Binary object identifier decoder. Bytes of one encoded identifier enter on
// oid, one byte per cycle while oid.ready is high, the final byte flagged by
// last_byte; the decoded subidentifiers leave on subids. A byte enters a
// registered input stage, and the record for its result word, if any, is then
// written into the queue. A nonzero prefix byte queues one record played out
// as five words (1, 3, 6, 1, prefix), one word per cycle while the consumer
// is ready; the header and group bytes that follow yield nothing for five
// bytes, so an unstalled consumer keeps up with one byte every cycle. Input
// ready is high while the queued records plus the byte in the input stage
// number fewer than QUEUE_DEPTH, so a stalled consumer holds back the byte
// stream only once the queue is taken up. On an error the identifier closes
// with one word carrying has_subid 0 and a nonzero status; earlier words of
// that identifier are then to be discarded by the consumer.
module oid_binary_decoder import oidd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	oidd_byte_if.sink   oid,
	oidd_subid_if.source subids
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic          busy;
	logic          push;
	oidd_rec_t     rec;
	logic [CW-1:0] level;
	logic          take;

	// Accept while the queue has room for a record from this byte and from the one in flight
	assign oid.ready = ({1'b0, level} + {{CW{1'b0}}, busy}) < (CW+1)'(QUEUE_DEPTH);
	assign take      = oid.valid && oid.ready;

	oidd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (oid.data_byte),
		.last_byte (oid.last_byte),
		.busy      (busy),
		.push      (push),
		.rec       (rec)
	);

	oidd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.rec    (rec),
		.level  (level),
		.subids (subids)
	);

endmodule
